// ----- rtl/core/laplmv_pkg.sv -----
`default_nettype none
package laplmv_pkg;

  localparam int COORD_BITS     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int INDEX_BITS     = 20;
  localparam int ITS_BITS       = 31;
  localparam int SUM_BITS       = 64;
  localparam int WEIGHT_BITS    = 48;
  localparam int COUNT_BITS     = 8;
  localparam int MAX_NEIGHBOURS = 255;
  localparam int STATUS_BITS    = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS + 2;
  localparam int ROOT_BITS  = SQ_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int HALF_BITS  = (ROOT_BITS + 1) / 2;
  localparam int PROD_BITS  = DIFF_BITS + ROOT_BITS;
  localparam int PP_BITS    = DIFF_BITS + HALF_BITS;
  localparam int DVD_BITS   = SUM_BITS + FRAC_BITS;
  localparam int DRM_BITS   = WEIGHT_BITS + 1;
  localparam int Q_HALF     = SUM_BITS / 2;
  localparam int PLO_BITS   = Q_HALF + ITS_BITS;
  localparam int PMUL_BITS  = SUM_BITS + ITS_BITS;

  localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_SAT  = 2'd2;

  localparam logic REG_WEIGHT_MODE   = 1'b0;
  localparam logic REG_INV_TIME_STEP = 1'b1;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        vertex_index;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic signed [COORD_BITS-1:0] neighbour_x;
    logic signed [COORD_BITS-1:0] neighbour_y;
    logic signed [COORD_BITS-1:0] neighbour_z;
    logic                         last_neighbour;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        out_vertex_index;
    logic signed [COORD_BITS-1:0] vel_x;
    logic signed [COORD_BITS-1:0] vel_y;
    logic signed [COORD_BITS-1:0] vel_z;
    logic [STATUS_BITS-1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]          index;
    logic [2:0][SUM_BITS-1:0]       sum;
    logic [WEIGHT_BITS-1:0]         weight;
    logic [COUNT_BITS-1:0]          count;
    logic                           weighted;
  } run_t;

endpackage
`default_nettype wire

// ----- rtl/core/laplmv_queue.sv -----
`default_nettype none
module laplmv_queue import laplmv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_data,
  output logic full,
  input  logic pop,
  output run_t pop_data,
  output logic empty
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  run_t                mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_r, rd_r;
  logic [CNT_BITS-1:0] cnt_r;

  assign full     = (cnt_r == CNT_BITS'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/laplmv_front.sv -----
`default_nettype none
module laplmv_front import laplmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  input  logic     weight_mode,
  input  logic     q_full,
  output logic     q_push,
  output run_t     q_data
);

  typedef enum logic [2:0] {F_IDLE, F_SQ, F_ROOT, F_MUL, F_ACC} fstate_t;

  localparam int STEP_BITS = $clog2(ROOT_BITS + 1);

  fstate_t                          state_r, state_nxt;
  logic [2:0][DIFF_BITS-1:0]        d_r, d_nxt;
  logic [INDEX_BITS-1:0]            index_r, index_nxt;
  logic                             mode_r, mode_nxt;
  logic                             last_r, last_nxt;
  logic                             skip_r, skip_nxt;
  logic [1:0]                       axis_r, axis_nxt;
  logic                             half_r, half_nxt;
  logic [SQ_BITS-1:0]               rad_r, rad_nxt;
  logic [REM_BITS-1:0]              rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]             root_r, root_nxt;
  logic [STEP_BITS-1:0]             step_r, step_nxt;
  logic [PROD_BITS-1:0]             acc_r, acc_nxt;
  logic [2:0][SUM_BITS-1:0]         term_r, term_nxt;
  logic [2:0][SUM_BITS-1:0]         sum_r, sum_nxt;
  logic [WEIGHT_BITS-1:0]           weight_r, weight_nxt;
  logic [COUNT_BITS-1:0]            count_r, count_nxt;

  logic                             accept;
  logic [DIFF_BITS-1:0]             mag;
  logic [2*DIFF_BITS-1:0]           sqr;
  logic [REM_BITS+1:0]              cur, trial;
  logic                             ge;
  logic [HALF_BITS-1:0]             len_sel;
  logic [PP_BITS-1:0]               pp;
  logic [PROD_BITS-1:0]             full_prod;
  logic [SUM_BITS-1:0]              t;
  logic [2:0][SUM_BITS-1:0]         sum_new;
  logic [2:0][SUM_BITS-1:0]         add;

  assign in_full = (state_r != F_IDLE) || q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    mag     = d_r[axis_r][DIFF_BITS-1] ? DIFF_BITS'(-d_r[axis_r]) : d_r[axis_r];
    sqr     = (2*DIFF_BITS)'(mag) * (2*DIFF_BITS)'(mag);
    cur     = {rem_r, rad_r[SQ_BITS-1 -: 2]};
    trial   = (REM_BITS+2)'({root_r, 2'b01});
    ge      = (cur >= trial);
    len_sel = half_r ? HALF_BITS'(root_r >> HALF_BITS) : root_r[HALF_BITS-1:0];
    pp      = PP_BITS'(mag) * PP_BITS'(len_sel);
    full_prod = acc_r + (PROD_BITS'(pp) << HALF_BITS);
    t       = SUM_BITS'(full_prod >> FRAC_BITS);
    for (int k = 0; k < 3; k++) begin
      add[k] = mode_r ? term_r[k]
                      : {{(SUM_BITS-DIFF_BITS){d_r[k][DIFF_BITS-1]}}, d_r[k]};
      sum_new[k] = sum_r[k] + add[k];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    d_nxt      = d_r;
    index_nxt  = index_r;
    mode_nxt   = mode_r;
    last_nxt   = last_r;
    skip_nxt   = skip_r;
    axis_nxt   = axis_r;
    half_nxt   = half_r;
    rad_nxt    = rad_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    term_nxt   = term_r;
    sum_nxt    = sum_r;
    weight_nxt = weight_r;
    count_nxt  = count_r;
    q_push     = 1'b0;
    q_data     = '0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          d_nxt[0]  = DIFF_BITS'($signed(in_item.neighbour_x)) -
                      DIFF_BITS'($signed(in_item.center_x));
          d_nxt[1]  = DIFF_BITS'($signed(in_item.neighbour_y)) -
                      DIFF_BITS'($signed(in_item.center_y));
          d_nxt[2]  = DIFF_BITS'($signed(in_item.neighbour_z)) -
                      DIFF_BITS'($signed(in_item.center_z));
          index_nxt = in_item.vertex_index;
          last_nxt  = in_item.last_neighbour;
          mode_nxt  = weight_mode;
          skip_nxt  = (count_r == COUNT_BITS'(MAX_NEIGHBOURS));
          axis_nxt  = '0;
          rad_nxt   = '0;
          state_nxt = (count_r == COUNT_BITS'(MAX_NEIGHBOURS)) ? F_ACC : F_SQ;
        end
      end
      F_SQ: begin
        rad_nxt = rad_r + SQ_BITS'(sqr);
        if (axis_r == 2'd2) begin
          axis_nxt  = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = F_ROOT;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      F_ROOT: begin
        rem_nxt  = ge ? REM_BITS'(cur - trial) : cur[REM_BITS-1:0];
        root_nxt = {root_r[ROOT_BITS-2:0], ge};
        rad_nxt  = {rad_r[SQ_BITS-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(ROOT_BITS - 1)) begin
          axis_nxt  = '0;
          half_nxt  = 1'b0;
          state_nxt = mode_r ? F_MUL : F_ACC;
        end
      end
      F_MUL: begin
        if (!half_r) begin
          acc_nxt  = PROD_BITS'(pp);
          half_nxt = 1'b1;
        end else begin
          term_nxt[axis_r] = d_r[axis_r][DIFF_BITS-1] ? -t : t;
          half_nxt = 1'b0;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = F_ACC;
          end else begin
            axis_nxt = axis_r + 1'b1;
          end
        end
      end
      F_ACC: begin
        if (!skip_r) begin
          sum_nxt    = sum_new;
          weight_nxt = weight_r + WEIGHT_BITS'(root_r);
          count_nxt  = count_r + 1'b1;
        end
        if (last_r) begin
          q_push          = 1'b1;
          q_data.index    = index_r;
          q_data.sum      = sum_nxt;
          q_data.weight   = weight_nxt;
          q_data.count    = count_nxt;
          q_data.weighted = mode_r;
          sum_nxt    = '0;
          weight_nxt = '0;
          count_nxt  = '0;
        end
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      sum_r    <= '0;
      weight_r <= '0;
      count_r  <= '0;
      axis_r   <= '0;
      half_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
      weight_r <= weight_nxt;
      count_r  <= count_nxt;
      axis_r   <= axis_nxt;
      half_r   <= half_nxt;
      step_r   <= step_nxt;
    end
    d_r     <= d_nxt;
    index_r <= index_nxt;
    mode_r  <= mode_nxt;
    last_r  <= last_nxt;
    skip_r  <= skip_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    acc_r   <= acc_nxt;
    term_r  <= term_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/laplmv_back.sv -----
`default_nettype none
module laplmv_back import laplmv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  run_t                q_data,
  input  logic [ITS_BITS-1:0] inv_time_step,
  output logic                out_empty,
  input  logic                out_pop,
  output out_item_t           out_item
);

  typedef enum logic [2:0] {
    B_IDLE, B_SETUP, B_DIV, B_MUL0, B_MUL1, B_NEXT, B_OUT
  } bstate_t;

  localparam int DSTEP_BITS = $clog2(DVD_BITS + 1);
  localparam logic [PMUL_BITS-1:0] POS_LIMIT = (PMUL_BITS'(1) << (COORD_BITS - 1)) - 1'b1;
  localparam logic [PMUL_BITS-1:0] NEG_LIMIT = PMUL_BITS'(1) << (COORD_BITS - 1);

  bstate_t                         state_r, state_nxt;
  run_t                            run_r, run_nxt;
  logic [1:0]                      axis_r, axis_nxt;
  logic                            neg_r, neg_nxt;
  logic [DVD_BITS-1:0]             dvd_r, dvd_nxt;
  logic [DRM_BITS-1:0]             drm_r, drm_nxt;
  logic [DSTEP_BITS-1:0]           step_r, step_nxt;
  logic [PLO_BITS-1:0]             p_r, p_nxt;
  logic [2:0][COORD_BITS-1:0]      vel_r, vel_nxt;
  logic                            sat_r, sat_nxt;
  logic [STATUS_BITS-1:0]          status_r, status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  out_item_t                       out_item_r, out_item_nxt;

  logic [SUM_BITS-1:0]             sel_sum, sel_mag;
  logic [WEIGHT_BITS-1:0]          dvs;
  logic [DRM_BITS-1:0]             cur;
  logic                            ge;
  logic [PLO_BITS-1:0]             hi_pp;
  logic [PMUL_BITS-1:0]            scaled, limit;
  logic [COORD_BITS-1:0]           lim_vel, mag_vel;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sel_sum = run_r.sum[axis_r];
    sel_mag = sel_sum[SUM_BITS-1] ? -sel_sum : sel_sum;
    dvs     = run_r.weighted ? run_r.weight : WEIGHT_BITS'(run_r.count);
    cur     = {drm_r[WEIGHT_BITS-1:0], dvd_r[DVD_BITS-1]};
    ge      = (cur >= {1'b0, dvs});
    hi_pp   = PLO_BITS'(dvd_r[SUM_BITS-1:Q_HALF]) * PLO_BITS'(inv_time_step);
    scaled  = (PMUL_BITS'(p_r) + (PMUL_BITS'(hi_pp) << Q_HALF)) >> FRAC_BITS;
    limit   = neg_r ? NEG_LIMIT : POS_LIMIT;
    lim_vel = neg_r ? -COORD_BITS'(limit) : COORD_BITS'(limit);
    mag_vel = neg_r ? -COORD_BITS'(scaled) : COORD_BITS'(scaled);
  end

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    axis_nxt      = axis_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    drm_nxt       = drm_r;
    step_nxt      = step_r;
    p_nxt         = p_r;
    vel_nxt       = vel_r;
    sat_nxt       = sat_r;
    status_nxt    = status_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          run_nxt   = q_data;
          axis_nxt  = '0;
          sat_nxt   = 1'b0;
          state_nxt = B_SETUP;
        end
      end
      B_SETUP: begin
        if (run_r.count == '0 || (run_r.weighted && run_r.weight == '0)) begin
          vel_nxt    = '0;
          status_nxt = STATUS_ZERO;
          state_nxt  = B_OUT;
        end else begin
          neg_nxt   = sel_sum[SUM_BITS-1];
          dvd_nxt   = run_r.weighted ? {sel_mag, {FRAC_BITS{1'b0}}} : DVD_BITS'(sel_mag);
          drm_nxt   = '0;
          step_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        drm_nxt  = ge ? cur - {1'b0, dvs} : cur;
        dvd_nxt  = {dvd_r[DVD_BITS-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == DSTEP_BITS'(DVD_BITS - 1)) begin
          state_nxt = B_MUL0;
        end
      end
      B_MUL0: begin
        if (dvd_r[DVD_BITS-1:SUM_BITS] != '0) begin
          vel_nxt[axis_r] = lim_vel;
          sat_nxt         = 1'b1;
          state_nxt       = B_NEXT;
        end else begin
          p_nxt     = PLO_BITS'(dvd_r[Q_HALF-1:0]) * PLO_BITS'(inv_time_step);
          state_nxt = B_MUL1;
        end
      end
      B_MUL1: begin
        if (scaled > limit) begin
          vel_nxt[axis_r] = lim_vel;
          sat_nxt         = 1'b1;
        end else begin
          vel_nxt[axis_r] = mag_vel;
        end
        state_nxt = B_NEXT;
      end
      B_NEXT: begin
        if (axis_r == 2'd2) begin
          status_nxt = sat_r ? STATUS_SAT : STATUS_OK;
          state_nxt  = B_OUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = B_SETUP;
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_item_nxt.out_vertex_index = run_r.index;
          out_item_nxt.vel_x            = vel_r[0];
          out_item_nxt.vel_y            = vel_r[1];
          out_item_nxt.vel_z            = vel_r[2];
          out_item_nxt.status           = status_r;
          out_valid_nxt                 = 1'b1;
          state_nxt                     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
    end
    run_r      <= run_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    drm_r      <= drm_nxt;
    p_r        <= p_nxt;
    vel_r      <= vel_nxt;
    sat_r      <= sat_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/laplacian_mesh_vertex_velocity.sv -----
// Laplacian smoothing velocity, one result per vertex.
// Input queue (in_push/in_full): one neighbour item per push; a run of items
// with the same vertex ends on an item with last_neighbour set.
// Result queue (out_empty/out_pop): one velocity item per run, held on
// out_item until popped; a stalled result holds and the block keeps working
// until its internal run queue fills, after which in_full stays high.
// Config: APB, register 0 weight_mode at 0x0, register 1 inv_time_step at 0x4.
// Front: an item past the run limit skips to accumulate without adding, else
// squares, a bit-serial square root and accumulate, plus a multiply with
// edge-length weights (33x17 partial products); one item at a time.
// Back: per axis of a run, an 80-step restoring divider, then the multiplies
// B_MUL0 and B_MUL1; a zero-weight run goes straight to a zero result.
// A two-entry run queue sits between front and back.
// Reset (synchronous, rst_n low) empties both queues, clears the
// accumulators and sets weight_mode 0, inv_time_step 1.0.
`default_nettype none
module laplacian_mesh_vertex_velocity import laplmv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                weight_mode_r;
  logic [ITS_BITS-1:0] inv_time_step_r;
  logic                q_push, q_pop, q_full, q_empty;
  run_t                q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INV_TIME_STEP) ? 32'(inv_time_step_r)
                                                   : 32'(weight_mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_mode_r   <= 1'b0;
      inv_time_step_r <= ITS_BITS'(1) << FRAC_BITS;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WEIGHT_MODE:   weight_mode_r   <= pwdata[0];
        REG_INV_TIME_STEP: inv_time_step_r <= pwdata[ITS_BITS-1:0];
        default: ;
      endcase
    end
  end

  laplmv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .weight_mode (weight_mode_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  laplmv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  laplmv_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .inv_time_step (inv_time_step_r),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_item      (out_item)
  );

`ifndef SYNTHESIS
  a_queue_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_full) else $error("run queue full but input open");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full) else $error("front took a second item");

  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.status == STATUS_ZERO) |->
    (out_item.vel_x == '0 && out_item.vel_y == '0 && out_item.vel_z == '0))
    else $error("zero-weight result with nonzero velocity");
`endif

endmodule
`default_nettype wire
